// ----- design/tcw_pkg.sv -----
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console writer: operation codes,
// character codes, the classified command and the links between its parts.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int unsigned COLUMNS_DEF   = 80;
  localparam int unsigned ROWS_DEF      = 25;
  localparam int unsigned TAB_CELLS_DEF = 4;

  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [7:0] CODE_NUL     = 8'h00;
  localparam logic [7:0] CODE_TAB     = 8'h09;
  localparam logic [7:0] CODE_NEWLINE = 8'h0A;
  localparam logic [7:0] CODE_SPACE   = 8'h20;
  localparam logic [7:0] TEXT_ATTR    = 8'h0F;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_CHAR,
    CMD_NEWLINE,
    CMD_TAB,
    CMD_READ,
    CMD_CLEAR
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
  } tcw_cmd_t;

  typedef struct packed {
    logic     valid;
    tcw_cmd_t cmd;
  } tcw_head_t;

  typedef struct packed {
    logic pop;
    logic init_busy;
  } tcw_back_stat_t;

endpackage

// ----- design/tcw_in_if.sv -----
// ----------------------------------------------------------------------------
// tcw_in_if
// Request channel of the text console writer: operation, character, cell.
// ----------------------------------------------------------------------------
interface tcw_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [7:0]  char_code;
  logic [10:0] cell_index;

  modport source (output valid, output operation, output char_code, output cell_index,
                  input ready);
  modport sink   (input valid, input operation, input char_code, input cell_index,
                  output ready);
endinterface

// ----- design/tcw_out_if.sv -----
// ----------------------------------------------------------------------------
// tcw_out_if
// Response channel of the text console writer: cell contents and cursor.
// ----------------------------------------------------------------------------
interface tcw_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  cell_char;
  logic [7:0]  cell_attr;
  logic [10:0] cursor_pos;

  modport source (output valid, output cell_char, output cell_attr, output cursor_pos,
                  input ready);
  modport sink   (input valid, input cell_char, input cell_attr, input cursor_pos,
                  output ready);
endinterface

// ----- design/tcw_ram.sv -----
// ----------------------------------------------------------------------------
// tcw_ram
// Generic RAM, one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/tcw_front.sv -----
// ----------------------------------------------------------------------------
// tcw_front
// Accepts requests, sorts them into command kinds and holds them in a
// two-entry queue for the execution engine.
// ----------------------------------------------------------------------------
module tcw_front import tcw_pkg::*; #(
  parameter int unsigned COLUMNS = COLUMNS_DEF,
  parameter int unsigned ROWS    = ROWS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  tcw_in_if.sink         req_i,
  input  tcw_back_stat_t stat_i,
  output tcw_head_t      head_o
);

  localparam int unsigned CELLS = COLUMNS * ROWS;

  tcw_cmd_t   mem_q [2];
  tcw_cmd_t   cmd;
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push;
  logic       pop;

  always_comb begin
    cmd.char_code  = req_i.char_code;
    cmd.cell_index = req_i.cell_index;
    cmd.kind       = CMD_NOP;
    unique case (req_i.operation)
      OP_PUT: begin
        priority if (req_i.char_code == CODE_NUL) cmd.kind = CMD_NOP;
        else if (req_i.char_code == CODE_NEWLINE) cmd.kind = CMD_NEWLINE;
        else if (req_i.char_code == CODE_TAB)     cmd.kind = CMD_TAB;
        else                                      cmd.kind = CMD_CHAR;
      end
      OP_READ: begin
        // out-of-range reads answer zeros, same as a no-op
        cmd.kind = (32'(req_i.cell_index) < 32'(CELLS)) ? CMD_READ : CMD_NOP;
      end
      OP_CLEAR: cmd.kind = CMD_CLEAR;
      default:  cmd.kind = CMD_NOP;
    endcase
  end

  assign req_i.ready = (count_q != 2'd2) && !stat_i.init_busy;
  assign push        = req_i.valid && req_i.ready;
  assign pop         = stat_i.pop && (count_q != 2'd0);

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop  ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= cmd;
    end
  end

  assign head_o.valid = (count_q != 2'd0);
  assign head_o.cmd   = mem_q[rd_ptr_q];

endmodule

// ----- design/tcw_back.sv -----
// ----------------------------------------------------------------------------
// tcw_back
// Execution engine: owns the cell RAM and the cursor, carries out puts,
// tabs, reads, clears and scrolls, and holds the response register.
// ----------------------------------------------------------------------------
module tcw_back import tcw_pkg::*; #(
  parameter int unsigned COLUMNS   = COLUMNS_DEF,
  parameter int unsigned ROWS      = ROWS_DEF,
  parameter int unsigned TAB_CELLS = TAB_CELLS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tcw_head_t      head_i,
  output tcw_back_stat_t stat_o,
  tcw_out_if.source      rsp_o
);

  localparam int unsigned CELLS    = COLUMNS * ROWS;
  localparam int unsigned AW       = $clog2(CELLS);
  localparam int unsigned CW       = $clog2(CELLS + 1);
  localparam int unsigned COLW     = $clog2(COLUMNS);
  localparam int unsigned TW       = (TAB_CELLS > 1) ? $clog2(TAB_CELLS) : 1;
  localparam int unsigned COL_STEP = COLUMNS % TAB_CELLS;
  localparam int unsigned LAST_MOD = ((ROWS - 1) * COLUMNS) % TAB_CELLS;

  localparam logic [2:0] ST_INIT   = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_TAB    = 3'd2;
  localparam logic [2:0] ST_READ   = 3'd3;
  localparam logic [2:0] ST_CLEAR  = 3'd4;
  localparam logic [2:0] ST_SCR_RD = 3'd5;
  localparam logic [2:0] ST_SCR_WR = 3'd6;
  localparam logic [2:0] ST_ZERO   = 3'd7;

  localparam logic [AW-1:0] ADDR_LAST     = AW'(CELLS - 1);
  localparam logic [AW-1:0] ADDR_MOVE_END = AW'(CELLS - COLUMNS - 1);
  localparam logic [AW-1:0] ADDR_LAST_ROW = AW'(CELLS - COLUMNS);

  logic [2:0]      state_q, state_d;
  logic [CW-1:0]   cursor_q, cursor_d;
  logic [COLW-1:0] col_q, col_d;
  logic [TW-1:0]   tab_q, tab_d;
  logic [TW-1:0]   rowmod_q, rowmod_d;
  logic [AW-1:0]   addr_q, addr_d;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [15:0]     ram_wdata;
  logic [AW-1:0]   ram_raddr;
  logic [15:0]     ram_rdata;

  logic            out_valid_q;
  logic [7:0]      out_char_q, out_attr_q;
  logic [10:0]     out_cursor_q;
  logic            out_free;
  logic            emit;
  logic [7:0]      emit_char, emit_attr;
  logic            pop;

  // one-cell advance and newline of the cursor
  logic [CW-1:0]   cur_inc, cur_nl;
  logic            col_last;
  logic [COLW-1:0] col_inc;
  logic [TW-1:0]   tab_inc;
  logic [TW:0]     rm_sum;
  logic [TW-1:0]   rowmod_adv;
  logic            inc_full, nl_full;

  always_comb begin
    cur_inc  = cursor_q + CW'(1);
    cur_nl   = cursor_q + CW'(COLUMNS) - CW'(col_q);
    col_last = (col_q == COLW'(COLUMNS - 1));
    col_inc  = col_last ? '0 : col_q + COLW'(1);
    tab_inc  = (tab_q == TW'(TAB_CELLS - 1)) ? '0 : tab_q + TW'(1);
    rm_sum   = {1'b0, rowmod_q} + (TW + 1)'(COL_STEP);
    rowmod_adv = (rm_sum >= (TW + 1)'(TAB_CELLS)) ? TW'(rm_sum - (TW + 1)'(TAB_CELLS))
                                                   : TW'(rm_sum);
    inc_full = (cur_inc == CW'(CELLS));
    nl_full  = (cur_nl == CW'(CELLS));
  end

  assign out_free = !out_valid_q || rsp_o.ready;

  always_comb begin
    state_d   = state_q;
    cursor_d  = cursor_q;
    col_d     = col_q;
    tab_d     = tab_q;
    rowmod_d  = rowmod_q;
    addr_d    = addr_q;
    ram_we    = 1'b0;
    ram_waddr = addr_q;
    ram_wdata = '0;
    ram_raddr = addr_q;
    pop       = 1'b0;
    emit      = 1'b0;
    emit_char = '0;
    emit_attr = '0;
    unique case (state_q)
      ST_INIT, ST_CLEAR: begin
        ram_we = 1'b1;
        if (addr_q == ADDR_LAST) begin
          addr_d  = '0;
          state_d = ST_IDLE;
          emit    = (state_q == ST_CLEAR);
        end else begin
          addr_d = addr_q + AW'(1);
        end
      end
      ST_IDLE: begin
        if (head_i.valid && out_free) begin
          pop = 1'b1;
          unique case (head_i.cmd.kind)
            CMD_CHAR: begin
              ram_we    = 1'b1;
              ram_waddr = AW'(cursor_q);
              ram_wdata = {TEXT_ATTR, head_i.cmd.char_code};
              cursor_d  = cur_inc;
              col_d     = col_inc;
              tab_d     = tab_inc;
              rowmod_d  = col_last ? rowmod_adv : rowmod_q;
              if (inc_full) begin
                addr_d  = '0;
                state_d = ST_SCR_RD;
              end else begin
                emit = 1'b1;
              end
            end
            CMD_NEWLINE: begin
              cursor_d = cur_nl;
              col_d    = '0;
              tab_d    = rowmod_adv;
              rowmod_d = rowmod_adv;
              if (nl_full) begin
                addr_d  = '0;
                state_d = ST_SCR_RD;
              end else begin
                emit = 1'b1;
              end
            end
            CMD_TAB: state_d = ST_TAB;
            CMD_READ: begin
              ram_raddr = AW'(head_i.cmd.cell_index);
              state_d   = ST_READ;
            end
            CMD_CLEAR: begin
              addr_d  = '0;
              state_d = ST_CLEAR;
            end
            default: emit = 1'b1;
          endcase
        end
      end
      ST_TAB: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(cursor_q);
        ram_wdata = {TEXT_ATTR, CODE_SPACE};
        cursor_d  = cur_inc;
        col_d     = col_inc;
        tab_d     = tab_inc;
        rowmod_d  = col_last ? rowmod_adv : rowmod_q;
        if (inc_full) begin
          addr_d  = '0;
          state_d = ST_SCR_RD;
        end else if (tab_inc == '0) begin
          emit    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_READ: begin
        emit      = 1'b1;
        emit_char = ram_rdata[7:0];
        emit_attr = ram_rdata[15:8];
        state_d   = ST_IDLE;
      end
      ST_SCR_RD: begin
        ram_raddr = addr_q + AW'(COLUMNS);
        state_d   = ST_SCR_WR;
      end
      ST_SCR_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        if (addr_q == ADDR_MOVE_END) begin
          addr_d  = ADDR_LAST_ROW;
          state_d = ST_ZERO;
        end else begin
          addr_d  = addr_q + AW'(1);
          state_d = ST_SCR_RD;
        end
      end
      ST_ZERO: begin
        ram_we = 1'b1;
        if (addr_q == ADDR_LAST) begin
          // park the cursor at the start of the last row
          cursor_d = CW'(CELLS - COLUMNS);
          col_d    = '0;
          tab_d    = TW'(LAST_MOD);
          rowmod_d = TW'(LAST_MOD);
          addr_d   = '0;
          emit     = 1'b1;
          state_d  = ST_IDLE;
        end else begin
          addr_d = addr_q + AW'(1);
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      cursor_q    <= '0;
      col_q       <= '0;
      tab_q       <= '0;
      rowmod_q    <= '0;
      addr_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cursor_q <= cursor_d;
      col_q    <= col_d;
      tab_q    <= tab_d;
      rowmod_q <= rowmod_d;
      addr_q   <= addr_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_char_q   <= emit_char;
      out_attr_q   <= emit_attr;
      out_cursor_q <= 11'(cursor_d);
    end
  end

  tcw_ram #(
    .WIDTH (16),
    .DEPTH (CELLS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign stat_o.pop       = pop;
  assign stat_o.init_busy = (state_q == ST_INIT);

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.cell_char  = out_char_q;
  assign rsp_o.cell_attr  = out_attr_q;
  assign rsp_o.cursor_pos = out_cursor_q;

endmodule

// ----- design/text_console_writer_core.sv -----
// ----------------------------------------------------------------------------
// text_console_writer_core
// Character-cell text console writer with a COLUMNS by ROWS cell RAM.
// ----------------------------------------------------------------------------
// Requests arrive on req_i (put character, read cell, clear screen); every
// request returns exactly one beat on rsp_o with the cell contents (reads)
// and the cursor position after the operation.
// Requests enter a two-entry queue; the engine behind it works on one
// request at a time, bound by the single write port of the cell RAM.
// Work between request beat and response beat:
//   plain put, newline, null, out-of-range read: handled in the idle state
//   tab: n spaces written up to the next tab stop (n up to TAB_CELLS)
//   read: one RAM read in the read state; clear: all COLUMNS*ROWS cells written
//   a put, newline or tab that fills the screen adds a scroll: it copies
//   COLUMNS*ROWS - COLUMNS cells up a row, then wipes the last row.
// After reset the engine wipes all COLUMNS*ROWS cells of the RAM (2000 by
// default), one cell a cycle; req_i.ready stays low until then.
// A stalled rsp_o holds its beat; the queue keeps taking requests until full.
// ----------------------------------------------------------------------------
module text_console_writer_core import tcw_pkg::*; #(
  parameter int unsigned COLUMNS   = COLUMNS_DEF,
  parameter int unsigned ROWS      = ROWS_DEF,
  parameter int unsigned TAB_CELLS = TAB_CELLS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tcw_in_if.sink    req_i,
  tcw_out_if.source rsp_o
);

  tcw_head_t      head;
  tcw_back_stat_t stat;

  tcw_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .stat_i (stat),
    .head_o (head)
  );

  tcw_back #(
    .COLUMNS   (COLUMNS),
    .ROWS      (ROWS),
    .TAB_CELLS (TAB_CELLS)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .stat_o (stat),
    .rsp_o  (rsp_o)
  );

endmodule

// ----- design/tcw_checker.sv -----
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks of the text console writer, bound to the top level.
// ----------------------------------------------------------------------------
module tcw_checker #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [7:0]  cell_char_i,
  input logic [7:0]  cell_attr_i,
  input logic [10:0] cursor_pos_i
);

  localparam int unsigned CELLS = COLUMNS * ROWS;

  logic       in_acc, out_acc;
  logic [2:0] pend_q;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // requests taken but not yet answered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + {2'b0, in_acc} - {2'b0, out_acc};
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("response dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(cell_char_i) && $stable(cell_attr_i) && $stable(cursor_pos_i))
    else $error("response changed while stalled");

  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pend_q != 3'd0)
    else $error("response without a pending request");

  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 3'd3)
    else $error("more requests in flight than queue and engine hold");

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (CELLS > 2048) || (32'(cursor_pos_i) < 32'(CELLS)))
    else $error("cursor beyond the screen");

endmodule

bind text_console_writer_core tcw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tcw_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (req_i.valid),
  .in_ready_i   (req_i.ready),
  .out_valid_i  (rsp_o.valid),
  .out_ready_i  (rsp_o.ready),
  .cell_char_i  (rsp_o.cell_char),
  .cell_attr_i  (rsp_o.cell_attr),
  .cursor_pos_i (rsp_o.cursor_pos)
);
